/* hw/rtl/sync_length_payload_deframer_core_macros.svh */
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared property wrappers for the deframer core checks.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_PAYLOAD_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_PAYLOAD_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slpd_pkg.sv */
// ----------------------------------------------------------------------------
// Deframer package
// Register map, configuration bundle and field widths of the deframer.
// ----------------------------------------------------------------------------
package slpd_pkg;

  localparam int BYTE_W  = 8;
  localparam int TSIZE_W = 7;
  localparam int IDX_W   = 15;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int REG_SEL_W = 3;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_SYNC_FIRST  = 3'd0,
    REG_SYNC_SECOND = 3'd1,
    REG_SYNC_THIRD  = 3'd2,
    REG_SYNC_FOURTH = 3'd3,
    REG_MAX_COUNT   = 3'd4,
    REG_TOKEN_SIZE  = 3'd5
  } reg_sel_t;

  localparam logic [BYTE_W-1:0]  MAX_COUNT_RESET  = 8'd64;
  localparam logic [TSIZE_W-1:0] TOKEN_SIZE_RESET = 7'd16;

  typedef struct packed {
    logic [BYTE_W-1:0]  sync_first;
    logic [BYTE_W-1:0]  sync_second;
    logic [BYTE_W-1:0]  sync_third;
    logic [BYTE_W-1:0]  sync_fourth;
    logic [BYTE_W-1:0]  max_token_count;
    logic [TSIZE_W-1:0] token_size_bytes;
  } cfg_t;

endpackage

/* hw/rtl/sync_length_payload_deframer_core.sv */
// ----------------------------------------------------------------------------
// Sync/length payload deframer core
// Hunts for a four-byte sync word, reads a token-count length byte and
// streams the payload bytes out with index, last flag and packet length.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. Each accepted word is decoded in the
// same cycle by the phase machine and any payload byte lands in a single
// output register, so throughput is one word per cycle. The input stalls
// only while that output register holds a word that the sink has not taken.
// No clearing pass after reset.
module sync_length_payload_deframer_core #(
  parameter int COUNT_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [slpd_pkg::DATA_W-1:0]  pwdata,
  output logic [slpd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slpd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slpd_pkg::BYTE_W-1:0]  payload_byte,
  output logic [slpd_pkg::IDX_W-1:0]   byte_index,
  output logic                         last,
  output logic [slpd_pkg::IDX_W-1:0]   packet_length
);
  import slpd_pkg::*;

`include "sync_length_payload_deframer_core_macros.svh"

  localparam int WIDE_W = (COUNT_BITS > IDX_W) ? COUNT_BITS : IDX_W;
  localparam int LEN_W  = BYTE_W + TSIZE_W + 1;
  localparam logic [LEN_W:0] LEN_MAX = (LEN_W+1)'((1 << COUNT_BITS) - 1);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_SYNC3 = 3'd2,
    PH_SYNC4 = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  cfg_t cfg;

  slpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t                  phase, phase_next;
  logic [COUNT_BITS-1:0]   byte_count, byte_count_next;
  logic [COUNT_BITS-1:0]   expected_count, expected_count_next;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [LEN_W-2:0]        prod;
  logic [LEN_W-1:0]        len;
  logic                    len_ok;
  logic [WIDE_W-1:0]       idx_wide, plen_wide;
  logic                    in_fire;
  logic                    emit, emit_last;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  // payload length = count * token size * 2
  assign prod   = (LEN_W-1)'(rx_byte) * (LEN_W-1)'(cfg.token_size_bytes);
  assign len    = {prod, 1'b0};
  assign len_ok = (rx_byte != '0) && (rx_byte <= cfg.max_token_count) &&
                  (len != '0) && ((LEN_W+1)'(len) <= LEN_MAX);

  assign count_inc = byte_count + COUNT_BITS'(1);
  assign idx_wide  = WIDE_W'(byte_count);
  assign plen_wide = WIDE_W'(expected_count);

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    expected_count_next = expected_count;
    emit                = 1'b0;
    emit_last           = 1'b0;
    case (phase)
      PH_SYNC1: begin
        byte_count_next = '0;
        if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: phase_next = (rx_byte == cfg.sync_second) ? PH_SYNC3 : PH_SYNC1;
      PH_SYNC3: phase_next = (rx_byte == cfg.sync_third)  ? PH_SYNC4 : PH_SYNC1;
      PH_SYNC4: phase_next = (rx_byte == cfg.sync_fourth) ? PH_LEN   : PH_SYNC1;
      PH_LEN: begin
        if (len_ok) begin
          expected_count_next = len[COUNT_BITS-1:0];
          byte_count_next     = '0;
          phase_next          = PH_DATA;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_DATA: begin
        emit            = 1'b1;
        byte_count_next = count_inc;
        if (count_inc == expected_count) begin
          emit_last  = 1'b1;
          phase_next = PH_SYNC1;
        end
      end
      default: phase_next = PH_SYNC1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      byte_count     <= '0;
      expected_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire && emit) out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
      if (in_fire) begin
        phase          <= phase_next;
        byte_count     <= byte_count_next;
        expected_count <= expected_count_next;
        if (emit) begin
          payload_byte  <= rx_byte;
          byte_index    <= idx_wide[IDX_W-1:0];
          last          <= emit_last;
          packet_length <= emit_last ? plen_wide[IDX_W-1:0] : '0;
        end
      end
    end
  end

  `SLPD_ASSERT_NOW(a_last_length, out_valid && last,
    packet_length == IDX_W'(byte_index + IDX_W'(1)), "last word length mismatch")
  `SLPD_ASSERT_NOW(a_length_zero, out_valid && !last,
    packet_length == '0, "packet_length set on a non-final word")
  `SLPD_ASSERT_NEXT(a_no_spurious, in_fire && (phase != PH_DATA),
    !out_valid, "output word produced outside the payload phase")

endmodule

/* hw/rtl/slpd_regs.sv */
// ----------------------------------------------------------------------------
// Deframer register file
// APB-style register bank holding sync bytes, count limit and token size.
// ----------------------------------------------------------------------------
module slpd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [slpd_pkg::DATA_W-1:0]  pwdata,
  output logic [slpd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output slpd_pkg::cfg_t               cfg
);
  import slpd_pkg::*;

  reg_sel_t sel;
  logic     wr_en;

  assign sel    = reg_sel_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= '0;
      cfg.sync_second      <= '0;
      cfg.sync_third       <= '0;
      cfg.sync_fourth      <= '0;
      cfg.max_token_count  <= MAX_COUNT_RESET;
      cfg.token_size_bytes <= TOKEN_SIZE_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_SYNC_FIRST:  cfg.sync_first       <= pwdata[BYTE_W-1:0];
        REG_SYNC_SECOND: cfg.sync_second      <= pwdata[BYTE_W-1:0];
        REG_SYNC_THIRD:  cfg.sync_third       <= pwdata[BYTE_W-1:0];
        REG_SYNC_FOURTH: cfg.sync_fourth      <= pwdata[BYTE_W-1:0];
        REG_MAX_COUNT:   cfg.max_token_count  <= pwdata[BYTE_W-1:0];
        REG_TOKEN_SIZE:  cfg.token_size_bytes <= pwdata[TSIZE_W-1:0];
        default: ;  // unmapped slots drop the write
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SYNC_FIRST:  prdata = DATA_W'(cfg.sync_first);
      REG_SYNC_SECOND: prdata = DATA_W'(cfg.sync_second);
      REG_SYNC_THIRD:  prdata = DATA_W'(cfg.sync_third);
      REG_SYNC_FOURTH: prdata = DATA_W'(cfg.sync_fourth);
      REG_MAX_COUNT:   prdata = DATA_W'(cfg.max_token_count);
      REG_TOKEN_SIZE:  prdata = DATA_W'(cfg.token_size_bytes);
      default:         prdata = '0;
    endcase
  end

endmodule
